/* src/mrp_pkg.sv */
// ----------------------------------------------------------------------------
// mrp_pkg: shared types and constants of the MIPS relocation patcher
// Relocation type codes, status codes, item layouts and the control word
// that steers the chain of pending HI16 cells.
// ----------------------------------------------------------------------------
package mrp_pkg;

    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_WORD32 = 3'd1;
    localparam logic [2:0] ACT_JUMP26 = 3'd2;
    localparam logic [2:0] ACT_HI16   = 3'd3;
    localparam logic [2:0] ACT_LO16   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DANGEROUS = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_UNHANDLED = 3'd3;
    localparam logic [2:0] ST_PEND_FULL = 3'd4;
    localparam logic [2:0] ST_HI_MISMATCH = 3'd5;

    localparam logic [31:0] REGION_MASK = 32'hf000_0000;
    localparam logic [31:0] JUMP_INCR   = 32'd4;

    // gp_symbol is set when the symbol is the GP displacement symbol of
    // position-independent code, which this block does not support.
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] location;
        logic [31:0] current_word;
        logic [31:0] symbol_value;
        logic [31:0] place_address;
        logic        gp_symbol;
    } reloc_item_t;

    typedef struct packed {
        logic [31:0] out_location;
        logic [31:0] patched_word;
        logic        write_enable;
        logic [2:0]  status;
        logic        last;
    } result_item_t;

    // One parked HI16 relocation.
    typedef struct packed {
        logic [31:0] location;
        logic [31:0] word;
        logic [31:0] value;
    } pend_entry_t;

    // Shift command for the cell chain: push moves entries toward the tail,
    // pop moves them toward the head.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctl_t;

endpackage

/* src/mrp_stream_if.sv */
// ----------------------------------------------------------------------------
// mrp_stream_if: valid/ready channel
// Carries one item per handshake; an item moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface mrp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* src/mrp_cell.sv */
// ----------------------------------------------------------------------------
// mrp_cell: one slot of the pending HI16 chain
// Takes its left neighbor's entry on a push and its right neighbor's on a pop.
// ----------------------------------------------------------------------------
module mrp_cell (
    input  logic                clk,
    input  mrp_pkg::cell_ctl_t  ctl,
    input  mrp_pkg::pend_entry_t left_entry,
    input  mrp_pkg::pend_entry_t right_entry,
    output mrp_pkg::pend_entry_t entry
);
    import mrp_pkg::*;

    pend_entry_t entry_reg;
    pend_entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.push)
        begin
            entry_next = left_entry;
        end
        else if (ctl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* src/mips_relocation_patcher.sv */
// ----------------------------------------------------------------------------
// mips_relocation_patcher: MIPS32 REL relocation patcher with HI16/LO16 pairing
// Patches one relocation per item and resolves parked HI16 relocations when
// the matching LO16 arrives.
// ----------------------------------------------------------------------------
// Each input item is one relocation; each result item is one word to write
// back, with its location, a write enable, a status and a last flag. NONE,
// WORD32, JUMP26, HI16 and unknown types, and an LO16 with nothing parked,
// give exactly one result, and the block accepts the next item in the
// following cycle as long as the output register is free or being emptied.
// HI16 items are parked in a row of PENDING_DEPTH cells that works as a
// stack: a push shifts every entry one cell toward the tail, so the newest
// entry always sits in the head cell. A full row leaves the HI16 unparked
// and reports pending full. An LO16 item with parked entries is captured
// first; then the head cell is patched and popped once per entry (the row
// shifts toward the head), and last the LO16's own word goes out. Input is
// not accepted while that drain runs. The output register decouples the two
// channels; back-pressure on the result side stalls the drain and the
// acceptance of input.
// ----------------------------------------------------------------------------
module mips_relocation_patcher #(
    parameter int PENDING_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    mrp_stream_if.sink    reloc,
    mrp_stream_if.source  result
);
    import mrp_pkg::*;

    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } state_t;

    state_t         state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic           out_valid_reg, out_valid_next;
    result_item_t   out_item_reg, out_item_next;

    // Captured LO16 relocation, held while the parked entries drain.
    logic [31:0]    lo_loc_reg, lo_loc_next;
    logic [31:0]    lo_word_reg, lo_word_next;
    logic [31:0]    lo_value_reg, lo_value_next;
    logic [31:0]    lo_sum_reg, lo_sum_next;
    logic [2:0]     lo_base_reg, lo_base_next;

    reloc_item_t    item;
    logic           out_free;
    logic           accept;
    logic [2:0]     base_status;
    logic [31:0]    low_addend;
    logic [31:0]    jump_region;
    logic [2:0]     jump_status;
    logic [31:0]    hi_sum;
    logic [15:0]    hi_half;

    cell_ctl_t      ctl;
    pend_entry_t    new_entry;
    pend_entry_t    chain [PENDING_DEPTH];

    assign item        = reloc.payload;
    assign out_free    = !out_valid_reg || result.ready;
    assign reloc.ready = (state_reg == S_IDLE) && out_free;
    assign accept      = reloc.valid && reloc.ready;

    assign base_status = item.gp_symbol ? ST_UNHANDLED : ST_OK;

    // Sign-extended low 16 bits of the LO16 instruction's addend.
    assign low_addend  = {{16{item.current_word[15]}}, item.current_word[15:0]};

    assign jump_region = item.place_address + JUMP_INCR;

    always_comb
    begin
        jump_status = base_status;
        if (item.symbol_value[1:0] != 2'b00)
        begin
            jump_status = ST_DANGEROUS;
        end
        if ((item.symbol_value & REGION_MASK) != (jump_region & REGION_MASK))
        begin
            jump_status = ST_OVERFLOW;
        end
    end

    // The head cell's HI16 half, rounded by the low half's sign bit.
    assign hi_sum  = {chain[0].word[15:0], 16'h0000} + lo_sum_reg;
    assign hi_half = hi_sum[31:16] + {15'd0, hi_sum[15]};

    assign new_entry.location = item.location;
    assign new_entry.word     = item.current_word;
    assign new_entry.value    = item.symbol_value;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_item_next  = out_item_reg;
        lo_loc_next    = lo_loc_reg;
        lo_word_next   = lo_word_reg;
        lo_value_next  = lo_value_reg;
        lo_sum_next    = lo_sum_reg;
        lo_base_next   = lo_base_reg;
        ctl.push       = 1'b0;
        ctl.pop        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_item_next.out_location = item.location;
                    out_item_next.patched_word = item.current_word;
                    out_item_next.write_enable = 1'b1;
                    out_item_next.status       = base_status;
                    out_item_next.last         = 1'b1;
                    out_valid_next             = 1'b1;
                    case (item.action)
                        ACT_NONE:
                        begin
                            out_item_next.status = base_status;
                        end
                        ACT_WORD32:
                        begin
                            out_item_next.patched_word =
                                item.current_word + item.symbol_value;
                        end
                        ACT_JUMP26:
                        begin
                            out_item_next.patched_word = {item.current_word[31:26],
                                item.current_word[25:0] + item.symbol_value[27:2]};
                            out_item_next.status = jump_status;
                        end
                        ACT_HI16:
                        begin
                            out_item_next.write_enable = 1'b0;
                            if (count_reg == CNT_W'(PENDING_DEPTH))
                            begin
                                out_item_next.status = ST_PEND_FULL;
                            end
                            else
                            begin
                                ctl.push   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_LO16:
                        begin
                            lo_loc_next   = item.location;
                            lo_word_next  = item.current_word;
                            lo_value_next = item.symbol_value;
                            lo_sum_next   = item.symbol_value + low_addend;
                            lo_base_next  = base_status;
                            if (count_reg != '0)
                            begin
                                // Parked entries go out first; hold the result.
                                out_valid_next = out_valid_reg && !result.ready;
                                out_item_next  = out_item_reg;
                                state_next     = S_DRAIN;
                            end
                            else
                            begin
                                out_item_next.patched_word = {item.current_word[31:16],
                                    item.symbol_value[15:0] + low_addend[15:0]};
                            end
                        end
                        default:
                        begin
                            out_item_next.status = ST_UNHANDLED;
                        end
                    endcase
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next.write_enable = 1'b1;
                    if (count_reg != '0)
                    begin
                        out_item_next.out_location = chain[0].location;
                        out_item_next.patched_word = {chain[0].word[31:16], hi_half};
                        out_item_next.status = (chain[0].value != lo_value_reg) ?
                                               ST_HI_MISMATCH : lo_base_reg;
                        out_item_next.last = 1'b0;
                        ctl.pop    = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        out_item_next.out_location = lo_loc_reg;
                        out_item_next.patched_word = {lo_word_reg[31:16],
                                                      lo_sum_reg[15:0]};
                        out_item_next.status = lo_base_reg;
                        out_item_next.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Row of pending cells; the head cell holds the newest HI16.
    for (genvar i = 0; i < PENDING_DEPTH; i++)
    begin : g_cell
        pend_entry_t left_entry;
        pend_entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_entry = new_entry;
        end
        else
        begin : g_body
            assign left_entry = chain[i-1];
        end

        if (i == PENDING_DEPTH - 1)
        begin : g_tail
            assign right_entry = chain[i];
        end
        else
        begin : g_inner
            assign right_entry = chain[i+1];
        end

        mrp_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (chain[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        lo_loc_reg   <= lo_loc_next;
        lo_word_reg  <= lo_word_next;
        lo_value_reg <= lo_value_next;
        lo_sum_reg   <= lo_sum_next;
        lo_base_reg  <= lo_base_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

endmodule
